// ===== rtl/core/ctsde_pkg.sv =====
// Package for the keypad time-setting controller.
// Holds key codes, cursor positions, register indexes, state and result types
// and small decimal helper functions. Depends on nothing.
package ctsde_pkg;

  localparam int unsigned NumDigits = 6;
  localparam int unsigned CurW      = 3;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned ValW      = 7;
  localparam int unsigned KeyW      = 4;

  localparam logic [KeyW-1:0] KeyStar     = 4'd10;
  localparam logic [KeyW-1:0] KeyHash     = 4'd11;
  localparam logic [KeyW-1:0] KeyLastDigit = 4'd9;

  localparam logic [CurW-1:0] PosHourTens  = 3'd0;
  localparam logic [CurW-1:0] PosHourUnits = 3'd1;
  localparam logic [CurW-1:0] PosMinTens   = 3'd2;
  localparam logic [CurW-1:0] PosMinUnits  = 3'd3;
  localparam logic [CurW-1:0] PosSecTens   = 3'd4;
  localparam logic [CurW-1:0] PosSecUnits  = 3'd5;

  localparam logic [ValW-1:0]   MaxVal   = 7'd99;
  localparam logic [DigitW-1:0] MaxDigit = 4'd9;

  typedef enum logic [1:0] {
    CFG_HOUR_LIMIT   = 2'd0,
    CFG_MINUTE_LIMIT = 2'd1,
    CFG_SECOND_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                              set_mode;
    logic [CurW-1:0]                   cursor;
    logic [NumDigits-1:0][DigitW-1:0]  digits;
  } state_t;

  typedef struct packed {
    logic              setting_active;
    logic [CurW-1:0]   cursor_pos;
    logic              echo_valid;
    logic [DigitW-1:0] echo_digit;
    logic              time_valid;
    logic [ValW-1:0]   new_hour;
    logic [ValW-1:0]   new_minute;
    logic [ValW-1:0]   new_second;
  } result_t;

  // Clamp a 7-bit value to 99.
  function automatic logic [ValW-1:0] sat99(input logic [ValW-1:0] v);
    return (v > MaxVal) ? MaxVal : v;
  endfunction

  // Tens digit of a value up to 99, by multiplying with 205/2048.
  function automatic logic [DigitW-1:0] tens_of(input logic [ValW-1:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

  // Units digit of a value up to 99.
  function automatic logic [DigitW-1:0] units_of(input logic [ValW-1:0] v);
    logic [DigitW-1:0] t;
    logic [ValW-1:0]   r;
    t = tens_of(v);
    r = v - ({t, 3'b000} + {2'b00, t, 1'b0});
    return r[DigitW-1:0];
  endfunction

  // Compose tens and units into a value.
  function automatic logic [ValW-1:0] compose(input logic [DigitW-1:0] t,
                                              input logic [DigitW-1:0] u);
    return {t, 3'b000} + {2'b00, t, 1'b0} + {3'b000, u};
  endfunction

endpackage

// ===== rtl/core/ctsde_step.sv =====
// Next-state and result logic for one key transaction of the time-setting controller.
// Purely combinational; uses ctsde_pkg for types and decimal helpers.
module ctsde_step (
  input  ctsde_pkg::state_t         state_i,
  input  logic [3:0]                key_i,
  input  logic [6:0]                clock_hour_i,
  input  logic [6:0]                clock_minute_i,
  input  logic [6:0]                clock_second_i,
  input  logic [6:0]                hour_limit_i,
  input  logic [6:0]                minute_limit_i,
  input  logic [6:0]                second_limit_i,
  output ctsde_pkg::state_t         state_o,
  output ctsde_pkg::result_t        result_o
);
  import ctsde_pkg::*;

  logic [ValW-1:0] ch, cm, cs, hl;

  assign ch = sat99(clock_hour_i);
  assign cm = sat99(clock_minute_i);
  assign cs = sat99(clock_second_i);
  assign hl = sat99(hour_limit_i);

  always_comb begin
    logic [CurW-1:0]   cur;
    logic [DigitW-1:0] bound;
    state_t            st;
    result_t           res;

    cur   = (state_i.cursor >= CurW'(NumDigits)) ? PosHourTens : state_i.cursor;
    st    = state_i;
    st.cursor = cur;
    res   = '0;
    bound = MaxDigit;

    if (!state_i.set_mode) begin
      if (key_i == KeyStar) begin
        st.digits[0] = tens_of(ch);
        st.digits[1] = units_of(ch);
        st.digits[2] = tens_of(cm);
        st.digits[3] = units_of(cm);
        st.digits[4] = tens_of(cs);
        st.digits[5] = units_of(cs);
        st.cursor    = PosHourTens;
        st.set_mode  = 1'b1;
      end
    end else if (key_i == KeyStar) begin
      st.set_mode    = 1'b0;
      res.time_valid = 1'b1;
      res.new_hour   = compose(state_i.digits[0], state_i.digits[1]);
      res.new_minute = compose(state_i.digits[2], state_i.digits[3]);
      res.new_second = compose(state_i.digits[4], state_i.digits[5]);
    end else if (key_i == KeyHash) begin
      st.cursor = (cur == PosHourTens) ? PosSecUnits : cur - CurW'(1);
    end else if (key_i <= KeyLastDigit) begin
      case (cur)
        PosHourTens:  bound = tens_of(hl);
        PosHourUnits: bound = units_of(hl);
        PosMinTens:   bound = tens_of(sat99(minute_limit_i));
        PosSecTens:   bound = tens_of(sat99(second_limit_i));
        default:      bound = MaxDigit;
      endcase
      res.echo_valid = 1'b1;
      if (key_i > bound) begin
        res.echo_digit = state_i.digits[cur];
      end else begin
        st.digits[cur] = key_i;
        res.echo_digit = key_i;
        st.cursor      = (cur == PosSecUnits) ? PosHourTens : cur + CurW'(1);
      end
    end

    res.setting_active = st.set_mode;
    res.cursor_pos     = st.cursor;
    state_o  = st;
    result_o = res;
  end

endmodule

// ===== rtl/core/clock_time_set_digit_entry.sv =====
// Keypad time-setting controller, top level.
// A key transaction is registered in the input register on acceptance and then processed
// into the result register, which presents the result.
// Throughput: one key per cycle while the downstream side takes each result; a held result stalls key input.
// Reset (async, active low): idle mode, cursor 0, digits zero, limits 23/59/59.
// Depends on ctsde_pkg and ctsde_step.
module clock_time_set_digit_entry (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Key input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0 up: key[3:0], clock_hour[10:4], clock_minute[17:11],
  // clock_second[24:18], zero fill[31:25].
  input  logic [31:0] s_axis_tdata,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, from bit 0 up: setting_active[0], cursor_pos[3:1], echo_digit[7:4],
  // new_hour[14:8], new_minute[21:15], new_second[28:22], zero fill[31:29].
  output logic [31:0] m_axis_tdata,
  // tuser, from bit 0 up: echo_valid[0], time_valid[1].
  output logic [1:0]  m_axis_tuser,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import ctsde_pkg::*;

  // Limit registers. Writes are always taken; an index beyond the list is dropped.
  logic [ValW-1:0] hour_limit_q, minute_limit_q, second_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_limit_q   <= 7'd23;
      minute_limit_q <= 7'd59;
      second_limit_q <= 7'd59;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HOUR_LIMIT:   hour_limit_q   <= cfg_data_i;
        CFG_MINUTE_LIMIT: minute_limit_q <= cfg_data_i;
        CFG_SECOND_LIMIT: second_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. It takes a new transaction whenever it is empty or its
  // contents move on into the result register in the same cycle.
  logic            in_valid_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] hour_q, minute_q, second_q;
  logic            advance;
  logic            out_valid_q;
  result_t         result_q, result_d;
  state_t          state_q, state_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      key_q    <= s_axis_tdata[3:0];
      hour_q   <= s_axis_tdata[10:4];
      minute_q <= s_axis_tdata[17:11];
      second_q <= s_axis_tdata[24:18];
    end
  end

  // Decode and state update for the registered key.
  ctsde_step u_step (
    .state_i        (state_q),
    .key_i          (key_q),
    .clock_hour_i   (hour_q),
    .clock_minute_i (minute_q),
    .clock_second_i (second_q),
    .hour_limit_i   (hour_limit_q),
    .minute_limit_i (minute_limit_q),
    .second_limit_i (second_limit_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Mode, cursor and digit registers change only when a key is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register. It holds a result until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, result_q.new_second, result_q.new_minute,
                          result_q.new_hour, result_q.echo_digit,
                          result_q.cursor_pos, result_q.setting_active};
  assign m_axis_tuser  = {result_q.time_valid, result_q.echo_valid};

endmodule
